>>> sv/hltf_pkg.sv
// shared types, register indexes and saturation helpers for the holt forecaster
// no dependencies

package hltf_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_ALPHA = 2'd0;
	localparam logic [1:0] REG_BETA  = 2'd1;
	localparam logic [1:0] REG_STEPS = 2'd2;

	localparam int unsigned GAIN_W   = 17;
	localparam int unsigned EST_W    = 48;   // level and trend width
	localparam int unsigned ALU_W    = 50;   // adder width before saturation
	localparam int unsigned PROD_W   = 43;   // 18 x 25 signed product
	localparam int unsigned PLO_W    = 41;   // unsigned low partial product
	localparam int unsigned ADJ_W    = 49;   // rounded correction term
	localparam int unsigned ACC_W    = 56;   // forecast accumulator
	localparam int unsigned STEP_W   = 7;

	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

	// control of the shared adder and multiplier
	typedef struct packed {
		logic sub;   // adder subtracts b from a
		logic hi;    // multiplier takes the upper half of the difference
	} hltf_ctrl_t;

	function automatic logic signed [EST_W-1:0] sat48(input logic signed [ALU_W-1:0] v);
		logic same;
		same = (&v[ALU_W-1:EST_W-1]) || !(|v[ALU_W-1:EST_W-1]);
		if (same)
			return v[EST_W-1:0];
		else if (v[ALU_W-1])
			return {1'b1, {(EST_W-1){1'b0}}};
		else
			return {1'b0, {(EST_W-1){1'b1}}};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic same;
		same = (&v[ACC_W-1:31]) || !(|v[ACC_W-1:31]);
		if (same)
			return v[31:0];
		else if (v[ACC_W-1])
			return {1'b1, 31'd0};
		else
			return {1'b0, {31{1'b1}}};
	endfunction

endpackage

>>> sv/holt_linear_trend_forecaster.sv
// holt linear-trend forecaster: top level with sequencer, state and output register
// depends on hltf_pkg and hltf_arith
//
// channel   direction  transfer on              payload
// s_*       in         s_tvalid && s_tready     tdata: sample_value, tlast: end_of_series
// m_*       out        m_tvalid && m_tready     tdata: forecast_value, step_index; tlast: last
// cfg_*     in         cfg_we                   cfg_idx selects alpha, beta or step count
//
// the update runs two smoothing steps over one shared adder and one 18 x 25
// multiplier, two multiplier passes per step; a first sample of a series only
// seeds the level. an end-of-series item passes through a setup state and then
// emits one forecast per cycle while m_tready is high.
// s_tready is high only while the sequencer is idle; the output register lets
// the next item in while the final forecast still waits.
// reset clears the series state and sets the registers to their defaults.

module holt_linear_trend_forecaster #(
	parameter int unsigned MAX_HORIZON = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // [31:0] sample_value
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,    // [31:0] forecast_value, [38:32] step_index, [39] zero
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [16:0] cfg_data
);

	localparam int unsigned EW = hltf_pkg::EST_W;
	localparam int unsigned AW = hltf_pkg::ALU_W;
	localparam int unsigned SW = hltf_pkg::STEP_W;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_SEED = 11'b000_0000_0010,
		ST_SUM  = 11'b000_0000_0100,
		ST_DIFF = 11'b000_0000_1000,
		ST_MLO  = 11'b000_0001_0000,
		ST_MHI  = 11'b000_0010_0000,
		ST_ADDP = 11'b000_0100_0000,
		ST_UPD  = 11'b000_1000_0000,
		ST_DLT  = 11'b001_0000_0000,
		ST_FC0  = 11'b010_0000_0000,
		ST_EMIT = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	logic [16:0]    alpha_q, beta_q;
	logic [SW-1:0]  steps_q;

	logic [1:0]           seen_q;
	logic signed [EW-1:0] lvl_q, trd_q, old_q, cur_q, tgt_q, diff_q;
	logic signed [31:0]   y_q;
	logic                 last_q;
	logic                 ph_q;      // 0: level step, 1: trend step
	logic [hltf_pkg::PLO_W-1:0]         plo_q;
	logic signed [hltf_pkg::ADJ_W-1:0]  adj_q;
	logic signed [hltf_pkg::ACC_W-1:0]  acc_q;
	logic [SW-1:0]        k_q, n_q;

	logic                 ovld_q;
	logic signed [31:0]   ofv_q;
	logic [SW-1:0]        oidx_q;
	logic                 olast_q;

	hltf_pkg::hltf_ctrl_t               ctrl;
	logic signed [AW-1:0]               op_a, op_b;
	logic signed [EW-1:0]               alu_sum;
	logic signed [hltf_pkg::PROD_W-1:0] prod_q;
	logic [hltf_pkg::GAIN_W-1:0]        gain_raw, gain;
	logic [67:0]                        p_sum;
	logic [SW-1:0]                      n_clamp;
	logic                               in_xfer, slot_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign slot_free = !ovld_q || m_tready;

	assign gain_raw = ph_q ? beta_q : alpha_q;
	assign gain     = gain_raw[16] ? hltf_pkg::GAIN_ONE : gain_raw;

	assign n_clamp = (steps_q > SW'(MAX_HORIZON)) ? SW'(MAX_HORIZON) : steps_q;

	// rounded correction: floor((hi << 24 + lo + 2^15) / 2^16)
	assign p_sum = ({{25{prod_q[42]}}, prod_q} << 24) + {27'd0, plo_q} + 68'd32768;

	always_comb begin
		ctrl = '{sub: 1'b1, hi: 1'b0};
		op_a = AW'(lvl_q);
		op_b = AW'(trd_q);
		unique case (state_q)
			ST_SEED: begin
				op_a = AW'(y_q);
				op_b = AW'(lvl_q);
			end
			ST_SUM: begin
				ctrl.sub = 1'b0;
			end
			ST_DIFF: begin
				op_a = AW'(tgt_q);
				op_b = AW'(cur_q);
			end
			ST_MHI: begin
				ctrl.hi = 1'b1;
			end
			ST_UPD: begin
				ctrl.sub = 1'b0;
				op_a = AW'(cur_q);
				op_b = AW'(adj_q);
			end
			ST_DLT: begin
				op_b = AW'(old_q);
			end
			default: begin
			end
		endcase
	end

	hltf_arith u_arith (
		.clk    (clk),
		.ctrl   (ctrl),
		.a      (op_a),
		.b      (op_b),
		.gain   (gain),
		.diff   (diff_q),
		.sum    (alu_sum),
		.prod_q (prod_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 17'd32768;
			beta_q  <= 17'd32768;
			steps_q <= 7'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				hltf_pkg::REG_ALPHA: alpha_q <= cfg_data;
				hltf_pkg::REG_BETA:  beta_q  <= cfg_data;
				hltf_pkg::REG_STEPS: steps_q <= cfg_data[SW-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and series state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q  <= 2'd0;
			lvl_q   <= '0;
			trd_q   <= '0;
			ph_q    <= 1'b0;
			last_q  <= 1'b0;
			k_q     <= '0;
			n_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						last_q <= s_tlast;
						if (seen_q == 2'd0) begin
							lvl_q   <= EW'($signed(s_tdata));
							trd_q   <= '0;
							seen_q  <= 2'd1;
							state_q <= s_tlast ? ST_FC0 : ST_IDLE;
						end else if (seen_q == 2'd1) begin
							state_q <= ST_SEED;
						end else begin
							state_q <= ST_SUM;
						end
					end
				end
				ST_SEED: begin
					trd_q   <= alu_sum;
					seen_q  <= 2'd2;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					ph_q    <= 1'b0;
					state_q <= ST_DIFF;
				end
				ST_DIFF: state_q <= ST_MLO;
				ST_MLO:  state_q <= ST_MHI;
				ST_MHI:  state_q <= ST_ADDP;
				ST_ADDP: state_q <= ST_UPD;
				ST_UPD: begin
					if (!ph_q) begin
						lvl_q   <= alu_sum;
						state_q <= ST_DLT;
					end else begin
						trd_q   <= alu_sum;
						state_q <= last_q ? ST_FC0 : ST_IDLE;
					end
				end
				ST_DLT: begin
					ph_q    <= 1'b1;
					state_q <= ST_DIFF;
				end
				ST_FC0: begin
					k_q <= 7'd1;
					n_q <= n_clamp;
					if (n_clamp == '0) begin
						seen_q  <= 2'd0;
						lvl_q   <= '0;
						trd_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						k_q <= k_q + 7'd1;
						if (k_q == n_q) begin
							seen_q  <= 2'd0;
							lvl_q   <= '0;
							trd_q   <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer)
			y_q <= $signed(s_tdata);
		unique case (state_q)
			ST_SUM: begin
				cur_q <= alu_sum;
				old_q <= lvl_q;
				tgt_q <= EW'(y_q);
			end
			ST_DLT: begin
				tgt_q <= alu_sum;
				cur_q <= trd_q;
			end
			ST_DIFF: diff_q <= alu_sum;
			ST_MHI:  plo_q  <= prod_q[hltf_pkg::PLO_W-1:0];
			ST_ADDP: adj_q  <= $signed(p_sum[64:16]);
			ST_FC0:  acc_q  <= hltf_pkg::ACC_W'(lvl_q) + hltf_pkg::ACC_W'(trd_q);
			ST_EMIT: begin
				if (slot_free)
					acc_q <= acc_q + hltf_pkg::ACC_W'(trd_q);
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (state_q == ST_EMIT && slot_free) begin
			ovld_q <= 1'b1;
		end else if (m_tready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && slot_free) begin
			ofv_q   <= hltf_pkg::sat32(acc_q);
			oidx_q  <= k_q;
			olast_q <= (k_q == n_q);
		end
	end

	assign m_tvalid = ovld_q;
	assign m_tdata  = {1'b0, oidx_q, ofv_q};
	assign m_tlast  = olast_q;

	// assertions

	a_seen_range: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q != 2'd3)
		else $error("series sample count out of range");

	a_emit_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (n_q != '0 && k_q <= n_q && n_q <= SW'(MAX_HORIZON)))
		else $error("forecast step outside run length");

	a_clear_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && slot_free && k_q == n_q)
		|=> (seen_q == 2'd0 && lvl_q == '0 && trd_q == '0 && m_tvalid && m_tlast))
		else $error("state not cleared after final forecast");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> !s_tready)
		else $error("input taken during forecast run");

endmodule

>>> sv/hltf_arith.sv
// shared arithmetic unit: 50-bit add/subtract saturated to 48 bits and a registered
// 18 x 25 multiplier that works on one half of a 48-bit difference at a time
// depends on hltf_pkg

module hltf_arith (
	input  logic                                   clk,
	input  hltf_pkg::hltf_ctrl_t                   ctrl,
	input  logic signed [hltf_pkg::ALU_W-1:0]      a,
	input  logic signed [hltf_pkg::ALU_W-1:0]      b,
	input  logic        [hltf_pkg::GAIN_W-1:0]     gain,
	input  logic signed [hltf_pkg::EST_W-1:0]      diff,
	output logic signed [hltf_pkg::EST_W-1:0]      sum,
	output logic signed [hltf_pkg::PROD_W-1:0]     prod_q
);

	logic signed [hltf_pkg::ALU_W-1:0]  raw_sum;
	logic signed [17:0]                 mul_a;
	logic signed [24:0]                 mul_b;
	logic signed [hltf_pkg::PROD_W-1:0] prod;

	assign raw_sum = ctrl.sub ? (a - b) : (a + b);
	assign sum     = hltf_pkg::sat48(raw_sum);

	// gain is unsigned; the low half is unsigned, the high half carries the sign
	assign mul_a = $signed({1'b0, gain});
	assign mul_b = ctrl.hi ? $signed({diff[47], diff[47:24]}) : $signed({1'b0, diff[23:0]});
	assign prod  = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_q <= prod;
	end

endmodule
